>>> hw/rtl/sc2a_pkg.sv
// Package for the scan code set 1 to ASCII translator.
// Holds the event kinds, the special key codes and the character tables.
// No dependencies.
package sc2a_pkg;

	typedef enum logic [1:0] {
		KIND_NONE    = 2'd0,
		KIND_CHAR    = 2'd1,
		KIND_NEWLINE = 2'd2,
		KIND_DELETE  = 2'd3
	} event_kind_t;

	typedef struct packed {
		logic set_shift;
		logic clr_shift;
		logic tog_caps;
	} flag_upd_t;

	typedef struct packed {
		logic shift_held;
		logic caps_on;
	} key_flags_t;

	localparam logic [7:0] SC_MAKE_LO   = 8'h01;
	localparam logic [7:0] SC_MAKE_HI   = 8'h3A;
	localparam logic [7:0] SC_BREAK_LO  = 8'h81;
	localparam logic [7:0] SC_BREAK_HI  = 8'hBA;
	localparam logic [7:0] SC_BREAK_BIT = 8'h80;

	localparam logic [7:0] SC_LSHIFT    = 8'h2A;
	localparam logic [7:0] SC_RSHIFT    = 8'h36;
	localparam logic [7:0] SC_ENTER     = 8'h1C;
	localparam logic [7:0] SC_BACKSPACE = 8'h0E;
	localparam logic [7:0] SC_SPACE     = 8'h39;
	localparam logic [7:0] SC_CAPS      = 8'h3A;

	localparam logic [6:0] CH_SPACE = 7'h20;
	localparam logic [6:0] CH_LOW_A = 7'h61;
	localparam logic [6:0] CH_LOW_Z = 7'h7A;

	function automatic logic [6:0] plain_char(input logic [5:0] key);
		logic [6:0] c;
		c = 7'h00;
		case (key)
			6'h02: c = 7'h31;
			6'h03: c = 7'h32;
			6'h04: c = 7'h33;
			6'h05: c = 7'h34;
			6'h06: c = 7'h35;
			6'h07: c = 7'h36;
			6'h08: c = 7'h37;
			6'h09: c = 7'h38;
			6'h0A: c = 7'h39;
			6'h0B: c = 7'h30;
			6'h0C: c = 7'h2D;
			6'h0D: c = 7'h3D;
			6'h10: c = 7'h71;
			6'h11: c = 7'h77;
			6'h12: c = 7'h65;
			6'h13: c = 7'h72;
			6'h14: c = 7'h74;
			6'h15: c = 7'h79;
			6'h16: c = 7'h75;
			6'h17: c = 7'h69;
			6'h18: c = 7'h6F;
			6'h19: c = 7'h70;
			6'h1A: c = 7'h5B;
			6'h1B: c = 7'h5D;
			6'h1E: c = 7'h61;
			6'h1F: c = 7'h73;
			6'h20: c = 7'h64;
			6'h21: c = 7'h66;
			6'h22: c = 7'h67;
			6'h23: c = 7'h68;
			6'h24: c = 7'h6A;
			6'h25: c = 7'h6B;
			6'h26: c = 7'h6C;
			6'h27: c = 7'h3B;
			6'h28: c = 7'h27;
			6'h29: c = 7'h60;
			6'h2B: c = 7'h5C;
			6'h2C: c = 7'h7A;
			6'h2D: c = 7'h78;
			6'h2E: c = 7'h63;
			6'h2F: c = 7'h76;
			6'h30: c = 7'h62;
			6'h31: c = 7'h6E;
			6'h32: c = 7'h6D;
			6'h33: c = 7'h2C;
			6'h34: c = 7'h2E;
			6'h35: c = 7'h2F;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

	function automatic logic [6:0] shifted_char(input logic [5:0] key);
		logic [6:0] c;
		c = 7'h00;
		case (key)
			6'h02: c = 7'h21;
			6'h03: c = 7'h40;
			6'h04: c = 7'h23;
			6'h05: c = 7'h24;
			6'h06: c = 7'h25;
			6'h07: c = 7'h5E;
			6'h08: c = 7'h26;
			6'h09: c = 7'h2A;
			6'h0A: c = 7'h28;
			6'h0B: c = 7'h29;
			6'h0C: c = 7'h5F;
			6'h0D: c = 7'h2B;
			6'h10: c = 7'h51;
			6'h11: c = 7'h57;
			6'h12: c = 7'h45;
			6'h13: c = 7'h52;
			6'h14: c = 7'h54;
			6'h15: c = 7'h59;
			6'h16: c = 7'h55;
			6'h17: c = 7'h49;
			6'h18: c = 7'h4F;
			6'h19: c = 7'h50;
			6'h1A: c = 7'h7B;
			6'h1B: c = 7'h7D;
			6'h1E: c = 7'h41;
			6'h1F: c = 7'h53;
			6'h20: c = 7'h44;
			6'h21: c = 7'h46;
			6'h22: c = 7'h47;
			6'h23: c = 7'h48;
			6'h24: c = 7'h4A;
			6'h25: c = 7'h4B;
			6'h26: c = 7'h4C;
			6'h27: c = 7'h3A;
			6'h28: c = 7'h22;
			6'h29: c = 7'h7E;
			6'h2B: c = 7'h7C;
			6'h2C: c = 7'h5A;
			6'h2D: c = 7'h58;
			6'h2E: c = 7'h43;
			6'h2F: c = 7'h56;
			6'h30: c = 7'h42;
			6'h31: c = 7'h4E;
			6'h32: c = 7'h4D;
			6'h33: c = 7'h3C;
			6'h34: c = 7'h3E;
			6'h35: c = 7'h3F;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

endpackage

>>> hw/rtl/sc2a_decode.sv
// Combinational decoder from one scan code and the current key flags
// to an event and the flag updates it causes. Depends on sc2a_pkg.
module sc2a_decode (
	input  logic [7:0]              code,
	input  sc2a_pkg::key_flags_t    flags,
	output sc2a_pkg::event_kind_t   kind,
	output logic [6:0]              char_code,
	output sc2a_pkg::flag_upd_t     upd
);
	import sc2a_pkg::*;

	logic       is_make;
	logic       is_break;
	logic [6:0] base;
	logic [6:0] shifted;
	logic       lower_alpha;
	logic       upper;

	assign is_make     = (code >= SC_MAKE_LO) && (code <= SC_MAKE_HI);
	assign is_break    = (code >= SC_BREAK_LO) && (code <= SC_BREAK_HI);
	assign base        = plain_char(code[5:0]);
	assign shifted     = shifted_char(code[5:0]);
	assign lower_alpha = (base >= CH_LOW_A) && (base <= CH_LOW_Z);
	assign upper       = lower_alpha ? (flags.caps_on ^ flags.shift_held) : flags.shift_held;

	always_comb begin
		kind      = KIND_NONE;
		char_code = 7'h00;
		upd       = '0;
		if (is_make) begin
			unique case (code)
				SC_LSHIFT, SC_RSHIFT: upd.set_shift = 1'b1;
				SC_ENTER:             kind = KIND_NEWLINE;
				SC_CAPS:              upd.tog_caps = 1'b1;
				SC_BACKSPACE:         kind = KIND_DELETE;
				SC_SPACE: begin
					kind      = KIND_CHAR;
					char_code = CH_SPACE;
				end
				default: begin
					if (base != 7'h00) begin
						kind      = KIND_CHAR;
						char_code = upper ? shifted : base;
					end
				end
			endcase
		end else if (is_break) begin
			if ((code == (SC_LSHIFT | SC_BREAK_BIT)) || (code == (SC_RSHIFT | SC_BREAK_BIT))) begin
				upd.clr_shift = 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/sc2a_key_state.sv
// Shift-held and caps-lock flag registers.
// Applies the decoder's updates when an item is processed. Depends on sc2a_pkg.
module sc2a_key_state (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  sc2a_pkg::flag_upd_t  upd,
	output sc2a_pkg::key_flags_t flags
);
	import sc2a_pkg::*;

	logic shift_q;
	logic caps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 1'b0;
			caps_q  <= 1'b0;
		end else if (en) begin
			if (upd.set_shift) begin
				shift_q <= 1'b1;
			end else if (upd.clr_shift) begin
				shift_q <= 1'b0;
			end
			if (upd.tog_caps) begin
				caps_q <= ~caps_q;
			end
		end
	end

	assign flags.shift_held = shift_q;
	assign flags.caps_on    = caps_q;

endmodule

>>> hw/rtl/scan_code_to_ascii.sv
// Scan code set 1 to ASCII translator, top level.
// Instantiates sc2a_decode and sc2a_key_state; depends on sc2a_pkg.
// Each scan code item yields one event item, which passes through an input register and then a
// result register before it is presented on the event outputs, and a new item is taken in every
// cycle while the output is not stalled. The table lookup and the flag update lie between the two
// registers.
module scan_code_to_ascii (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  scan_valid,
	output logic                  scan_stall,
	input  logic [7:0]            scan_code,
	output logic                  event_valid,
	input  logic                  event_stall,
	output sc2a_pkg::event_kind_t event_kind,
	output logic [6:0]            char_code
);
	import sc2a_pkg::*;

	logic        valid_s1;
	logic [7:0]  code_s1;
	logic        valid_s2;
	event_kind_t kind_s2;
	logic [6:0]  char_s2;

	logic        ready_s2;
	logic        ready_s1;
	logic        adv_s1;

	event_kind_t dec_kind;
	logic [6:0]  dec_char;
	flag_upd_t   dec_upd;
	key_flags_t  flags;

	assign ready_s2   = !valid_s2 || !event_stall;
	assign ready_s1   = !valid_s1 || ready_s2;
	assign adv_s1     = valid_s1 && ready_s2;
	assign scan_stall = !ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= scan_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && scan_valid) begin
			code_s1 <= scan_code;
		end
	end

	sc2a_decode u_decode (
		.code      (code_s1),
		.flags     (flags),
		.kind      (dec_kind),
		.char_code (dec_char),
		.upd       (dec_upd)
	);

	sc2a_key_state u_key_state (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv_s1),
		.upd    (dec_upd),
		.flags  (flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			kind_s2 <= dec_kind;
			char_s2 <= dec_char;
		end
	end

	assign event_valid = valid_s2;
	assign event_kind  = kind_s2;
	assign char_code   = char_s2;

	a_flags_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(flags))
		else $error("key flags changed without an item being processed");

	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(event_valid && (event_kind != KIND_CHAR)) |-> (char_code == 7'h00))
		else $error("nonzero character on a non-character event");

	a_char_printable: assert property (@(posedge clk) disable iff (!arst_n)
		(event_valid && (event_kind == KIND_CHAR)) |-> (char_code >= CH_SPACE))
		else $error("character event carries a control code");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		scan_stall |-> (valid_s1 && valid_s2 && event_stall))
		else $error("input stalled while the pipeline has room");

endmodule
